// ===== rtl/rs_errors_erasures_decoder_unit_assert.svh =====
// ----------------------------------------------------------------------------
// RS(63,42) decoder assertion macros
// Shorthand for the concurrent checks at the end of the decoder top level.
// ----------------------------------------------------------------------------
`ifndef RS_ERRORS_ERASURES_DECODER_UNIT_ASSERT_SVH
`define RS_ERRORS_ERASURES_DECODER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define RSD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define RSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rsd_pkg.sv =====
// ----------------------------------------------------------------------------
// RS(63,42) decoder package
// GF(2^6) arithmetic (x^6 + x + 1), constant tables and shared types.
// ----------------------------------------------------------------------------
package rsd_pkg;

  localparam int CodeLen  = 63;
  localparam int MsgLen   = 42;
  localparam int ParLen   = 21;
  localparam int PolyLen  = ParLen + 1;
  localparam int FirstMsg = CodeLen - MsgLen;

  typedef logic [5:0] gf_t;
  typedef gf_t [PolyLen-1:0] poly_t;
  typedef logic signed [5:0] deg_t;
  typedef gf_t [CodeLen-1:0] pow_tab_t;
  typedef gf_t [63:0] inv_tab_t;

  // done/fail report of a decode phase
  typedef struct packed {
    logic done;
    logic fail;
  } phase_st_t;

  // field multiply, shift-and-add over six bits
  function automatic gf_t gmul(gf_t a, gf_t b);
    gf_t r;
    gf_t x;
    r = '0;
    x = a;
    for (int k = 0; k < 6; k++) begin
      if (b[k]) r ^= x;
      x = {x[4:0], 1'b0} ^ (x[5] ? 6'h03 : 6'h00);
    end
    return r;
  endfunction

  function automatic pow_tab_t build_pow();
    pow_tab_t t;
    t[0] = 6'd1;
    for (int n = 1; n < CodeLen; n++) t[n] = gmul(t[n-1], 6'd2);
    return t;
  endfunction

  // inverse of zero reads as zero
  function automatic inv_tab_t build_inv();
    inv_tab_t t;
    t = '0;
    for (int a = 1; a < 64; a++) begin
      for (int b = 1; b < 64; b++) begin
        if (gmul(gf_t'(a), gf_t'(b)) == 6'd1) t[a] = gf_t'(b);
      end
    end
    return t;
  endfunction

  localparam pow_tab_t AlphaPow = build_pow();
  localparam inv_tab_t InvTab   = build_inv();

  // degree of a polynomial, -1 when zero
  function automatic deg_t pdeg(poly_t p);
    deg_t d;
    d = '1;
    for (int k = 0; k < PolyLen; k++) begin
      if (p[k] != '0) d = deg_t'(k);
    end
    return d;
  endfunction

endpackage

// ===== rtl/rsd_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rsd_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 63
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/rsd_load.sv =====
// ----------------------------------------------------------------------------
// RS decoder load stage
// Syndrome and erasure locator lanes, updated as each word arrives.
// ----------------------------------------------------------------------------
module rsd_load (
  input  logic          clk,
  input  logic          rst,
  input  logic          clr,
  input  logic          take,
  input  rsd_pkg::gf_t  symbol,
  input  logic          erased,
  output rsd_pkg::poly_t syn,
  output rsd_pkg::poly_t loc0,
  output logic [5:0]    ecount
);

  rsd_pkg::poly_t pw;    // alpha^((j+1)*i) per syndrome lane
  rsd_pkg::gf_t   apos;  // alpha^i of the current position
  rsd_pkg::gf_t   w;

  assign w = erased ? '0 : symbol;

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      syn  <= '0;
      loc0 <= rsd_pkg::poly_t'(6'd1);
      for (int j = 0; j < rsd_pkg::PolyLen; j++) pw[j] <= 6'd1;
      apos   <= 6'd1;
      ecount <= '0;
    end else if (take) begin
      // syndrome lanes: S_j += w * alpha^((j+1)*i)
      for (int j = 0; j < rsd_pkg::ParLen; j++) begin
        syn[j] <= syn[j] ^ rsd_pkg::gmul(w, pw[j]);
        pw[j]  <= rsd_pkg::gmul(pw[j], rsd_pkg::AlphaPow[j+1]);
      end
      apos <= rsd_pkg::gmul(apos, rsd_pkg::AlphaPow[1]);
      // erasure locator times (x + alpha^i)
      if (erased) begin
        ecount <= 6'(ecount + 6'd1);
        if (ecount < 6'(rsd_pkg::ParLen)) begin
          loc0[0] <= rsd_pkg::gmul(loc0[0], apos);
          for (int k = 1; k < rsd_pkg::PolyLen; k++)
            loc0[k] <= loc0[k-1] ^ rsd_pkg::gmul(loc0[k], apos);
        end
      end
    end
  end

endmodule

// ===== rtl/rsd_kes.sv =====
// ----------------------------------------------------------------------------
// RS decoder key equation solver
// Modified syndrome, Euclid with erasure limits, normalization, locator merge.
// ----------------------------------------------------------------------------
module rsd_kes (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  rsd_pkg::poly_t      syn,
  input  rsd_pkg::poly_t      loc0,
  input  logic [5:0]          ecount,
  output rsd_pkg::phase_st_t  st,
  output rsd_pkg::poly_t      lam,
  output rsd_pkg::poly_t      omega
);

  typedef enum logic [3:0] {
    K_IDLE, K_MSYN, K_EINIT, K_TEST, K_INNER, K_SHIFT, K_UPD,
    K_NINV, K_NMUL, K_LINIT, K_LAM
  } state_t;

  state_t         state;
  rsd_pkg::poly_t ca, cb, acc;          // convolution unit
  logic [4:0]     ccnt;
  rsd_pkg::poly_t rp, rc, vp, vc, rcs, vcs;
  rsd_pkg::deg_t  mu, nu;
  logic [5:0]     iter;
  logic [4:0]     dc, sh;
  rsd_pkg::gf_t   inv, cf;
  rsd_pkg::deg_t  dcv, dvv, drv;

  assign dcv = rsd_pkg::pdeg(rc);
  assign dvv = rsd_pkg::pdeg(vc);
  assign drv = rsd_pkg::pdeg(rp);
  assign lam = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= K_IDLE;
      st    <= '0;
    end else begin
      st <= '0;
      case (state)
        K_IDLE: begin
          if (go) begin
            if (ecount > 6'(rsd_pkg::ParLen)) begin
              st <= '{done: 1'b1, fail: 1'b1};
            end else begin
              ca    <= loc0;
              cb    <= syn;
              acc   <= '0;
              ccnt  <= '0;
              mu    <= rsd_pkg::deg_t'((6'(rsd_pkg::ParLen) - ecount) >> 1);
              nu    <= rsd_pkg::deg_t'((ecount + 6'(rsd_pkg::ParLen - 1)) >> 1);
              state <= K_MSYN;
            end
          end
        end
        // acc += ca[0] * cb, then ca steps down, cb steps up
        K_MSYN, K_LAM: begin
          for (int k = 0; k < rsd_pkg::PolyLen; k++)
            acc[k] <= acc[k] ^ rsd_pkg::gmul(ca[0], cb[k]);
          ca   <= rsd_pkg::poly_t'(ca >> 6);
          cb   <= rsd_pkg::poly_t'(cb << 6);
          ccnt <= 5'(ccnt + 5'd1);
          if (ccnt == 5'(rsd_pkg::PolyLen - 1)) begin
            if (state == K_MSYN) begin
              state <= K_EINIT;
            end else begin
              st    <= '{done: 1'b1, fail: 1'b0};
              state <= K_IDLE;
            end
          end
        end
        K_EINIT: begin
          rc    <= {6'd0, acc[rsd_pkg::ParLen-1:0]};
          rp    <= rsd_pkg::poly_t'({6'd1, {(6 * rsd_pkg::ParLen){1'b0}}});
          vp    <= '0;
          vc    <= rsd_pkg::poly_t'(6'd1);
          iter  <= '0;
          state <= K_TEST;
        end
        // outer loop test
        K_TEST: begin
          if (!(dcv > nu || dvv > mu)) begin
            state <= K_NINV;
          end else if (dcv < 0 || iter > 6'(2 * rsd_pkg::PolyLen)) begin
            st    <= '{done: 1'b1, fail: 1'b1};
            state <= K_IDLE;
          end else begin
            iter  <= 6'(iter + 6'd1);
            dc    <= dcv[4:0];
            inv   <= rsd_pkg::InvTab[rc[dcv[4:0]]];
            state <= K_INNER;
          end
        end
        // one division step, or swap when rp drops below rc
        K_INNER: begin
          if (drv < $signed({1'b0, dc})) begin
            rp <= rc;
            rc <= rp;
            vp <= vc;
            vc <= vp;
            state <= K_TEST;
          end else begin
            cf    <= rsd_pkg::gmul(rp[drv[4:0]], inv);
            sh    <= 5'(drv[4:0] - dc);
            state <= K_SHIFT;
          end
        end
        K_SHIFT: begin
          rcs   <= rsd_pkg::poly_t'(rc << (int'(sh) * 6));
          vcs   <= rsd_pkg::poly_t'(vc << (int'(sh) * 6));
          state <= K_UPD;
        end
        K_UPD: begin
          for (int k = 0; k < rsd_pkg::PolyLen; k++) begin
            rp[k] <= rp[k] ^ rsd_pkg::gmul(cf, rcs[k]);
            vp[k] <= vp[k] ^ rsd_pkg::gmul(cf, vcs[k]);
          end
          state <= K_INNER;
        end
        // normalize by the multiplier's constant term
        K_NINV: begin
          if (vc[0] == '0) begin
            st    <= '{done: 1'b1, fail: 1'b1};
            state <= K_IDLE;
          end else begin
            inv   <= rsd_pkg::InvTab[vc[0]];
            state <= K_NMUL;
          end
        end
        K_NMUL: begin
          for (int k = 0; k < rsd_pkg::PolyLen; k++) begin
            vc[k]    <= rsd_pkg::gmul(vc[k], inv);
            omega[k] <= rsd_pkg::gmul(rc[k], inv);
          end
          state <= K_LINIT;
        end
        // merged locator = erasure locator * error locator
        K_LINIT: begin
          ca    <= loc0;
          cb    <= vc;
          acc   <= '0;
          ccnt  <= '0;
          state <= K_LAM;
        end
        default: state <= K_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/rsd_chien.sv =====
// ----------------------------------------------------------------------------
// RS decoder Chien search and Forney evaluation
// Steps through the EVAL, DEN and VAL states for each position; writes one error value per position.
// ----------------------------------------------------------------------------
module rsd_chien (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  rsd_pkg::poly_t     lam,
  input  rsd_pkg::poly_t     omega,
  output rsd_pkg::phase_st_t st,
  output logic               err_we,
  output logic [5:0]         err_addr,
  output rsd_pkg::gf_t       err_data
);

  typedef enum logic [1:0] {C_IDLE, C_EVAL, C_DEN, C_VAL} state_t;

  state_t         state;
  rsd_pkg::poly_t lc, oc;             // lanes scaled by alpha^(-i*k)
  rsd_pkg::gf_t   apos;               // alpha^i
  logic [5:0]     idx;
  rsd_pkg::gf_t   ls_r, odd_r, os_r, den;
  rsd_pkg::gf_t   ls_c, odd_c, os_c;

  // lane sums
  always_comb begin
    ls_c  = '0;
    odd_c = '0;
    os_c  = '0;
    for (int k = 0; k < rsd_pkg::PolyLen; k++) begin
      ls_c = ls_c ^ lc[k];
      os_c = os_c ^ oc[k];
      if (k % 2 == 1) odd_c = odd_c ^ lc[k];
    end
  end

  assign err_we   = (state == C_VAL);
  assign err_addr = idx;
  assign err_data = (ls_r == '0) ? rsd_pkg::gmul(os_r, rsd_pkg::InvTab[den]) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      st    <= '0;
    end else begin
      st <= '0;
      case (state)
        C_IDLE: begin
          if (go) begin
            lc    <= lam;
            oc    <= omega;
            apos  <= 6'd1;
            idx   <= '0;
            state <= C_EVAL;
          end
        end
        C_EVAL: begin
          ls_r  <= ls_c;
          odd_r <= odd_c;
          os_r  <= os_c;
          for (int k = 0; k < rsd_pkg::PolyLen; k++) begin
            lc[k] <= rsd_pkg::gmul(lc[k],
                       rsd_pkg::AlphaPow[(rsd_pkg::CodeLen - k) % rsd_pkg::CodeLen]);
            oc[k] <= rsd_pkg::gmul(oc[k],
                       rsd_pkg::AlphaPow[(rsd_pkg::CodeLen - k) % rsd_pkg::CodeLen]);
          end
          state <= C_DEN;
        end
        // derivative at x = odd part / x
        C_DEN: begin
          den   <= rsd_pkg::gmul(odd_r, apos);
          state <= C_VAL;
        end
        C_VAL: begin
          apos <= rsd_pkg::gmul(apos, rsd_pkg::AlphaPow[1]);
          idx  <= 6'(idx + 6'd1);
          if (ls_r == '0 && den == '0) begin
            st    <= '{done: 1'b1, fail: 1'b1};
            state <= C_IDLE;
          end else if (idx == 6'(rsd_pkg::CodeLen - 1)) begin
            st    <= '{done: 1'b1, fail: 1'b0};
            state <= C_IDLE;
          end else begin
            state <= C_EVAL;
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/rs_errors_erasures_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// RS(63,42) errors-and-erasures decoder
// Loads a 63-word block, decodes it and streams out the 42 message words.
// ----------------------------------------------------------------------------
// A block is loaded one word per cycle while start is high and busy is low,
// position 0 first; syndromes and the erasure locator build during the load.
// After the 63rd word busy rises for the decode: the modified syndrome, the
// Euclid loop of division steps and swaps, normalization and locator merge,
// and Chien/Forney over the positions (skipped when the key equation fails),
// then the 42 result words on consecutive cycles, registered behind the reads
// of the block store. The length of the decode is set by the Euclid divide
// steps and the per-position Chien loop. Results cannot be stalled;
// result_valid marks each word for one cycle.
`include "rs_errors_erasures_decoder_unit_assert.svh"

module rs_errors_erasures_decoder_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [5:0] symbol,
  input  logic       erased,
  output logic       result_valid,
  output logic [5:0] message_symbol,
  output logic       last_of_block,
  output logic       decode_failed
);

  typedef enum logic [1:0] {T_LOAD, T_KES, T_CHIEN, T_OUT} state_t;

  state_t             state;
  logic [5:0]         cnt, ra;
  logic               accept, kes_go, ch_go, ok, rd_v, rd_last, load_clr;
  rsd_pkg::poly_t     syn, loc0, lam, omega;
  logic [5:0]         ecount;
  rsd_pkg::phase_st_t kes_st, ch_st;
  logic               err_we;
  logic [5:0]         err_addr;
  rsd_pkg::gf_t       err_wdata, err_rdata;
  logic [6:0]         sym_rdata;
  rsd_pkg::gf_t       fixed;

  assign accept   = start && !busy;
  assign load_clr = (state == T_OUT) && (ra == 6'(rsd_pkg::CodeLen - 1));

  rsd_ram #(.WIDTH(7), .DEPTH(rsd_pkg::CodeLen)) u_sym_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (cnt),
    .wdata ({erased, symbol}),
    .raddr (ra),
    .rdata (sym_rdata)
  );

  rsd_ram #(.WIDTH(6), .DEPTH(rsd_pkg::CodeLen)) u_err_ram (
    .clk   (clk),
    .we    (err_we),
    .waddr (err_addr),
    .wdata (err_wdata),
    .raddr (ra),
    .rdata (err_rdata)
  );

  rsd_load u_load (
    .clk    (clk),
    .rst    (rst),
    .clr    (load_clr),
    .take   (accept),
    .symbol (symbol),
    .erased (erased),
    .syn    (syn),
    .loc0   (loc0),
    .ecount (ecount)
  );

  rsd_kes u_kes (
    .clk    (clk),
    .rst    (rst),
    .go     (kes_go),
    .syn    (syn),
    .loc0   (loc0),
    .ecount (ecount),
    .st     (kes_st),
    .lam    (lam),
    .omega  (omega)
  );

  rsd_chien u_chien (
    .clk      (clk),
    .rst      (rst),
    .go       (ch_go),
    .lam      (lam),
    .omega    (omega),
    .st       (ch_st),
    .err_we   (err_we),
    .err_addr (err_addr),
    .err_data (err_wdata)
  );

  // corrected word; a failed block goes out as received
  assign fixed = ok ? ((sym_rdata[6] ? 6'd0 : sym_rdata[5:0]) ^ err_rdata)
                    : sym_rdata[5:0];

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= T_LOAD;
      cnt           <= '0;
      busy          <= 1'b0;
      kes_go        <= 1'b0;
      ch_go         <= 1'b0;
      ok            <= 1'b0;
      rd_v          <= 1'b0;
      result_valid  <= 1'b0;
      last_of_block <= 1'b0;
      decode_failed <= 1'b0;
    end else begin
      kes_go        <= 1'b0;
      ch_go         <= 1'b0;
      rd_v          <= 1'b0;
      result_valid  <= rd_v;
      last_of_block <= rd_v && rd_last;
      decode_failed <= rd_v && !ok;
      message_symbol <= fixed;
      case (state)
        T_LOAD: begin
          if (accept) begin
            if (cnt == 6'(rsd_pkg::CodeLen - 1)) begin
              cnt    <= '0;
              busy   <= 1'b1;
              kes_go <= 1'b1;
              state  <= T_KES;
            end else begin
              cnt <= 6'(cnt + 6'd1);
            end
          end
        end
        T_KES: begin
          if (kes_st.done) begin
            if (kes_st.fail) begin
              ok    <= 1'b0;
              ra    <= 6'(rsd_pkg::FirstMsg);
              state <= T_OUT;
            end else begin
              ch_go <= 1'b1;
              state <= T_CHIEN;
            end
          end
        end
        T_CHIEN: begin
          if (ch_st.done) begin
            ok    <= !ch_st.fail;
            ra    <= 6'(rsd_pkg::FirstMsg);
            state <= T_OUT;
          end
        end
        T_OUT: begin
          rd_v    <= 1'b1;
          rd_last <= (ra == 6'(rsd_pkg::CodeLen - 1));
          if (ra == 6'(rsd_pkg::CodeLen - 1)) begin
            busy  <= 1'b0;
            state <= T_LOAD;
          end else begin
            ra <= 6'(ra + 6'd1);
          end
        end
        default: state <= T_LOAD;
      endcase
    end
  end

  // checks
  `RSD_ASSERT_NEXT(a_last_word_busy, accept && cnt == 6'(rsd_pkg::CodeLen - 1), busy, "block end did not raise busy")
  `RSD_ASSERT_IMPL(a_last_in_run, result_valid && last_of_block, $past(result_valid), "last word not in a run")
  `RSD_ASSERT_IMPL(a_phase_excl, kes_st.done, !ch_st.done, "two decode phases finished together")

endmodule

// ===== sim/rs_errors_erasures_decoder_unit_tb.sv =====
// ----------------------------------------------------------------------------
// RS(63,42) errors-and-erasures decoder testbench
// Feeds whole 63-word blocks: encoded codewords with injected errors and
// erasures, plus noise blocks. Every result word is checked against a
// behavioral decoder kept in this file.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rs_errors_erasures_decoder_unit_tb;

  localparam int N = 63;
  localparam int K = 42;
  localparam int P = 21;
  localparam int PL = P + 1;
  localparam int RANDOM_BLOCKS = 2;

  typedef logic [5:0] gf_w;
  typedef gf_w blk_t [N];
  typedef bit flg_t [N];
  typedef gf_w poly_w [PL];

  typedef enum int {MSG_ZERO, MSG_MAX, MSG_RAND, MSG_NOISE} msg_mode_e;

  typedef struct {
    msg_mode_e mode;
    int        nerr;
    int        nera;
    int        want_fail;  // -1: no typed expectation
  } blk_row_t;

  typedef struct {
    gf_w sym;
    bit  last;
    bit  fail;
  } out_word_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [5:0] symbol;
  logic erased;
  logic result_valid;
  logic [5:0] message_symbol;
  logic last_of_block;
  logic decode_failed;

  out_word_t pending_q[$];
  int mismatches = 0;
  int words_seen = 0;
  int blocks_sent = 0;
  int blocks_failed = 0;

  rs_errors_erasures_decoder_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .symbol(symbol), .erased(erased), .result_valid(result_valid),
    .message_symbol(message_symbol), .last_of_block(last_of_block),
    .decode_failed(decode_failed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------- field math
  function automatic gf_w fmul(gf_w a, gf_w b);
    gf_w r;
    gf_w x;
    r = '0;
    x = a;
    for (int k = 0; k < 6; k++) begin
      if (b[k]) r ^= x;
      x = {x[4:0], 1'b0} ^ (x[5] ? 6'h03 : 6'h00);
    end
    return r;
  endfunction

  function automatic gf_w fpow_alpha(int n);
    gf_w r;
    r = 6'd1;
    for (int k = 0; k < n % N; k++) r = fmul(r, 6'd2);
    return r;
  endfunction

  function automatic gf_w finv(gf_w a);
    gf_w r;
    r = 6'd1;
    for (int k = 0; k < N - 1; k++) r = fmul(r, a);
    return r;
  endfunction

  function automatic int fdeg(poly_w p);
    for (int i = PL - 1; i >= 0; i--) if (p[i] != 0) return i;
    return -1;
  endfunction

  function automatic gf_w feval(gf_w p[], gf_w x);
    gf_w r;
    r = '0;
    for (int i = p.size() - 1; i >= 0; i--) r = fmul(r, x) ^ p[i];
    return r;
  endfunction

  // ------------------------------------------------------- behavioral decoder
  // returns 1 on a failed decode; corrected (or raw) word in fixed
  function automatic bit predict_block(blk_t rx, flg_t er, output blk_t fixed);
    gf_w word[] = new[N];
    gf_w pl[] = new[PL];
    gf_w lam[] = new[PL];
    gf_w dlam[] = new[PL];
    gf_w omg[] = new[PL];
    poly_w eloc, rp, rc, vp, vc, tmp;
    gf_w syn[P];
    gf_w msyn[P];
    gf_w a, c, inv, x, den;
    int ecnt, mu, nu, iter, dc, d, sh;
    ecnt = 0;
    iter = 0;
    foreach (eloc[k]) eloc[k] = '0;
    eloc[0] = 6'd1;
    for (int i = 0; i < N; i++) begin
      word[i] = er[i] ? 6'd0 : rx[i];
      if (er[i]) begin
        ecnt++;
        if (ecnt <= P) begin
          a = fpow_alpha(i);
          for (int k = PL - 1; k >= 1; k--) eloc[k] = eloc[k-1] ^ fmul(eloc[k], a);
          eloc[0] = fmul(eloc[0], a);
        end
      end
    end
    fixed = rx;
    if (ecnt > P) return 1'b1;
    for (int k = 0; k < P; k++) syn[k] = feval(word, fpow_alpha(k + 1));
    for (int k = 0; k < P; k++) begin
      c = '0;
      for (int i = 0; i <= k; i++) c ^= fmul(eloc[i], syn[k-i]);
      msyn[k] = c;
    end
    // key equation by Euclid division steps
    foreach (rp[k]) begin rp[k] = '0; rc[k] = '0; vp[k] = '0; vc[k] = '0; end
    rp[P] = 6'd1;
    for (int k = 0; k < P; k++) rc[k] = msyn[k];
    vc[0] = 6'd1;
    mu = (P - ecnt) / 2;
    nu = (P + ecnt - 1) / 2;
    while (fdeg(rc) > nu || fdeg(vc) > mu) begin
      dc = fdeg(rc);
      if (dc < 0 || iter > 2 * PL) return 1'b1;
      iter++;
      inv = finv(rc[dc]);
      for (d = fdeg(rp); d >= dc; d = fdeg(rp)) begin
        sh = d - dc;
        c = fmul(rp[d], inv);
        for (int k = 0; k <= dc; k++) rp[k+sh] ^= fmul(c, rc[k]);
        for (int k = 0; k + sh < PL; k++) vp[k+sh] ^= fmul(c, vc[k]);
      end
      tmp = rp; rp = rc; rc = tmp;
      tmp = vp; vp = vc; vc = tmp;
    end
    if (vc[0] == 0) return 1'b1;
    c = finv(vc[0]);
    for (int k = 0; k < PL; k++) begin
      vc[k] = fmul(vc[k], c);
      omg[k] = fmul(rc[k], c);
    end
    // merge erasure and error locators, take formal derivative
    for (int k = 0; k < PL; k++) begin
      a = '0;
      for (int i = 0; i <= k; i++) a ^= fmul(eloc[i], vc[k-i]);
      lam[k] = a;
      dlam[k] = '0;
    end
    for (int k = 1; k < PL; k += 2) dlam[k-1] = lam[k];
    // Chien search and Forney values
    for (int i = 0; i < N; i++) begin
      fixed[i] = word[i];
      x = fpow_alpha(N - i);
      if (feval(lam, x) == 0) begin
        den = feval(dlam, x);
        if (den == 0) begin
          fixed = rx;
          return 1'b1;
        end
        fixed[i] = word[i] ^ fmul(feval(omg, x), finv(den));
      end
    end
    return 1'b0;
  endfunction

  // ------------------------------------------------------------ block builder
  function automatic blk_t make_codeword(blk_t msg);
    gf_w gen[PL];
    gf_w par[P];
    gf_w fb, r;
    blk_t cw;
    foreach (gen[k]) gen[k] = '0;
    gen[0] = 6'd1;
    for (int j = 1; j <= P; j++) begin
      r = fpow_alpha(j);
      for (int k = PL - 1; k >= 1; k--) gen[k] = gen[k-1] ^ fmul(gen[k], r);
      gen[0] = fmul(gen[0], r);
    end
    foreach (par[k]) par[k] = '0;
    for (int i = N - 1; i >= P; i--) begin
      fb = msg[i] ^ par[P-1];
      for (int k = P - 1; k >= 1; k--) par[k] = par[k-1] ^ fmul(fb, gen[k]);
      par[0] = fmul(fb, gen[0]);
    end
    cw = msg;
    for (int k = 0; k < P; k++) cw[k] = par[k];
    return cw;
  endfunction

  task automatic build_block(blk_row_t row, output blk_t rx, output flg_t er);
    blk_t msg;
    int perm[N];
    int j, t;
    for (int i = 0; i < N; i++) begin
      perm[i] = i;
      er[i] = 1'b0;
      case (row.mode)
        MSG_ZERO: msg[i] = 6'd0;
        MSG_MAX:  msg[i] = 6'd63;
        default:  msg[i] = gf_w'($urandom_range(0, 63));
      endcase
    end
    rx = (row.mode == MSG_NOISE) ? msg : make_codeword(msg);
    // distinct positions: errors first, erasures after
    for (int i = N - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = perm[i]; perm[i] = perm[j]; perm[j] = t;
    end
    for (int i = 0; i < row.nerr; i++) rx[perm[i]] ^= gf_w'($urandom_range(1, 63));
    for (int i = row.nerr; i < row.nerr + row.nera && i < N; i++) begin
      er[perm[i]] = 1'b1;
      rx[perm[i]] = gf_w'($urandom_range(0, 63));
    end
  endtask

  // --------------------------------------------------------------- word sender
  task automatic send_block(blk_row_t row);
    blk_t rx, fixed;
    flg_t er;
    int idx, burst;
    bit bad;
    out_word_t ow;
    build_block(row, rx, er);
    idx = 0;
    burst = ($urandom_range(0, 3) == 0) ? N : $urandom_range(1, 30);
    // start goes low between blocks
    @(posedge clk);
    start <= 1'b1;
    symbol <= rx[0];
    erased <= er[0];
    while (idx < N) begin
      @(posedge clk);
      if (start && !busy) begin
        idx++;
        burst--;
      end
      if (idx == N) begin
        start <= 1'b0;
      end else if (burst <= 0 && start) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst = $urandom_range(1, 30);
        start <= 1'b1;
        symbol <= rx[idx];
        erased <= er[idx];
      end else begin
        start <= 1'b1;
        symbol <= rx[idx];
        erased <= er[idx];
      end
    end
    bad = predict_block(rx, er, fixed);
    if (row.want_fail >= 0 && bad != row.want_fail[0]) begin
      mismatches++;
      if (mismatches <= 10)
        $display("block %0d: decode status %0b, table says %0d",
                 blocks_sent, bad, row.want_fail);
    end
    for (int k = 0; k < K; k++) begin
      ow = '{fixed[N-K+k], k == K - 1, bad};
      pending_q = {pending_q, ow};
    end
    blocks_sent++;
    if (bad) blocks_failed++;
  endtask

  // ---------------------------------------------------------- result checking
  always @(posedge clk) begin
    out_word_t w;
    if (!rst && result_valid) begin
      words_seen++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", message_symbol);
      end else begin
        w = pending_q.pop_front();
        if (w.sym !== message_symbol || w.last !== last_of_block ||
            w.fail !== decode_failed) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word %0d: exp sym %h last %b fail %b, got %h %b %b", words_seen,
                     w.sym, w.last, w.fail, message_symbol, last_of_block, decode_failed);
        end
      end
    end
  end

  // ------------------------------------------------------------------ stimulus
  blk_row_t directed_rows[] = '{
    '{MSG_ZERO,  0,  0, 0},
    '{MSG_RAND, 10,  0, 0},
    '{MSG_RAND,  0, 21, 0},
    '{MSG_RAND,  5, 11, 0},
    '{MSG_MAX,   0, 22, 1},
    '{MSG_RAND,  0, 63, 1}
  };

  initial begin
    blk_row_t row;
    int ne;
    rst = 1'b1;
    start = 1'b0;
    symbol = '0;
    erased = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[r]) send_block(directed_rows[r]);

    // hold off until the decoder has drained
    wait (pending_q.size() == 0);
    @(posedge clk);

    for (int b = 0; b < RANDOM_BLOCKS; b++) begin
      case ($urandom_range(0, 7))
        0: row = '{MSG_NOISE, 0, $urandom_range(0, 30), -1};
        1: row = '{MSG_RAND, $urandom_range(6, 15), $urandom_range(0, 25), -1};
        default: begin
          ne = $urandom_range(0, P);
          row = '{MSG_RAND, $urandom_range(0, (P - ne) / 2), ne, -1};
        end
      endcase
      send_block(row);
    end

    wait (pending_q.size() == 0);
    repeat (50) @(posedge clk);
    $display("blocks: %0d sent, %0d failed decodes; words checked: %0d",
             blocks_sent, blocks_failed, words_seen);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("mismatches: %0d", mismatches);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
